>>> hdl/tita_pkg.sv
// tita_pkg: shared types, codes and constants of the tickless idle tick accounting unit
// no dependencies; used by tita_div and tickless_idle_tick_accounting_unit

package tita_pkg;

    // tick width default
    localparam int TICK_BITS_DEF = 32;

    // configuration register widths
    localparam int SPS_W  = 16;
    localparam int TR_W   = 14;
    localparam int WCLK_W = 21;
    localparam int CMAX_W = 17;
    localparam int THR_W  = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPS       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAKE_CLK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEEP_THR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEEP_DIS  = 3'd5;

    // configuration reset values
    localparam logic [SPS_W-1:0]  SPS_RST  = 16'd32768;
    localparam logic [TR_W-1:0]   TR_RST   = 14'd1000;
    localparam logic [WCLK_W-1:0] WCLK_RST = 21'd2048;
    localparam logic [CMAX_W-1:0] CMAX_RST = 17'd65536;
    localparam logic [THR_W-1:0]  THR_RST  = 8'd5;

    // largest usable wakeup count, keeps the load value in 16 bits
    localparam logic [CMAX_W-1:0] WAKE_COUNT_LIMIT = 17'd65536;

    // seconds in one day
    localparam int DAY_W = 17;
    localparam logic [DAY_W-1:0] SECONDS_PER_DAY = DAY_W'(24 * 60 * 60);

    // sleep mode codes
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_LIGHT = 2'd1;
    localparam logic [1:0] MODE_DEEP  = 2'd2;
    localparam logic [1:0] MODE_ABORT = 2'd3;

    // shared divider geometry
    localparam int DIV_Q_W     = 32;
    localparam int DIV_D_W     = 21;
    localparam int DIV_HI_W    = DIV_D_W + 1;
    localparam int DIV_STEPS   = DIV_Q_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic                start;
        logic [DIV_HI_W-1:0] hi;
        logic [DIV_Q_W-1:0]  lo;
        logic [DIV_D_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic               ovf;
        logic [DIV_Q_W-1:0] quo;
    } div_stat_t;

endpackage

>>> hdl/tita_div.sv
// tita_div: shared restoring divider, one quotient bit per cycle
// depends on tita_pkg (div_req_t, div_stat_t, divider widths)

module tita_div
    import tita_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  div_req_t  req,
    output div_stat_t stat
);

    logic                 busy_reg;
    logic                 done_reg;
    logic                 ovf_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_Q_W-1:0]   quo_reg;
    logic [DIV_D_W-1:0]   dvs_reg;

    logic [DIV_D_W:0]     trial;
    logic [DIV_D_W:0]     diff;
    logic                 fits;

    // shift in the next dividend bit and try the subtract
    assign trial = {rem_reg, quo_reg[DIV_Q_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
                // quotient would not fit 32 bits
                ovf_reg  <= req.hi >= {1'b0, req.divisor};
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            dvs_reg <= req.divisor;
            rem_reg <= req.hi[DIV_D_W-1:0];
            quo_reg <= req.lo;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            quo_reg <= {quo_reg[DIV_Q_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;
    assign stat.quo  = quo_reg;

endmodule

>>> hdl/tickless_idle_tick_accounting_unit.sv
// tickless_idle_tick_accounting_unit: top level, sequencer, config registers, result register
// depends on tita_pkg and tita_div
//
//  channel   direction  signals                                        use
//  s_        in         s_valid/s_ready + command, ticks, rtc fields   plan or finish request
//  m_        out        m_valid/m_ready + mode, counter, tick fields    one result per request
//  cfg_      in         cfg_valid/cfg_ready + cfg_index, cfg_data       register write, always ready
//
//  divisions: each 32-bit division runs in the shared divider; a deep plan needs two,
//  a finish one
//  reset: synchronous active-low aresetn; config takes its default values, state clears
//  stalls: a held result sits in the output register while the next request is accepted;
//  the sequencer only waits in its last step if that register is still full

module tickless_idle_tick_accounting_unit
    import tita_pkg::*;
#(
    parameter int TICK_BITS = TICK_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  logic [31:0]           s_expected_idle_ticks,
    input  logic                  s_stop_blocked,
    input  logic [31:0]           s_rtc_subticks,
    input  logic                  s_rtc_valid,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_sleep_mode,
    output logic [15:0]           m_wakeup_counter,
    output logic [31:0]           m_completed_ticks,
    output logic [31:0]           m_step_ticks,
    output logic                  m_tick_pending,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ticks are kept to at most 32 bits
    localparam int TW    = (TICK_BITS >= 32) ? 32 : TICK_BITS;
    localparam int NUM_W = 55;
    localparam int MX_W  = 34;
    localparam int MY_W  = 21;
    localparam int ST_W  = 4;

    localparam logic [ST_W-1:0] ST_IDLE   = 4'd0;
    localparam logic [ST_W-1:0] ST_PLAN_A = 4'd1;   // zero check, count max times tick rate
    localparam logic [ST_W-1:0] ST_PLAN_B = 4'd2;   // start max idle division
    localparam logic [ST_W-1:0] ST_PLAN_C = 4'd3;   // clamp idle ticks
    localparam logic [ST_W-1:0] ST_PLAN_D = 4'd4;   // pick mode, idle times wakeup clock
    localparam logic [ST_W-1:0] ST_PLAN_E = 4'd5;   // round-up bias
    localparam logic [ST_W-1:0] ST_PLAN_F = 4'd6;   // start count division
    localparam logic [ST_W-1:0] ST_PLAN_G = 4'd7;   // clamp counts, arm deep sleep
    localparam logic [ST_W-1:0] ST_FIN_A  = 4'd8;   // snapshot check, day length
    localparam logic [ST_W-1:0] ST_FIN_B  = 4'd9;   // day minus before
    localparam logic [ST_W-1:0] ST_FIN_C  = 4'd10;  // elapsed subticks with day wrap
    localparam logic [ST_W-1:0] ST_FIN_D  = 4'd11;  // elapsed times tick rate
    localparam logic [ST_W-1:0] ST_FIN_E  = 4'd12;  // start tick division
    localparam logic [ST_W-1:0] ST_FIN_F  = 4'd13;  // clamp to planned ticks
    localparam logic [ST_W-1:0] ST_OUT    = 4'd14;  // hand result to output register

    // configuration registers
    logic [SPS_W-1:0]  sps_reg;
    logic [TR_W-1:0]   tr_reg;
    logic [WCLK_W-1:0] wclk_reg;
    logic [CMAX_W-1:0] cmax_reg;
    logic [THR_W-1:0]  thr_reg;
    logic              deep_dis_reg;

    // zero rates read as one, count max limited to the 16-bit load range
    logic [SPS_W-1:0]  sps_eff;
    logic [TR_W-1:0]   tr_eff;
    logic [WCLK_W-1:0] wclk_eff;
    logic [CMAX_W-1:0] cmax_eff;

    // sequencer and accounting state
    logic [ST_W-1:0]   state_reg,   state_next;
    logic              snap_reg,    snap_next;
    logic [TW-1:0]     planned_reg, planned_next;
    logic [31:0]       before_reg,  before_next;

    // working registers
    logic [31:0]       idle_reg,    idle_next;
    logic              blk_reg,     blk_next;
    logic [31:0]       cap_reg,     cap_next;
    logic              rv_reg,      rv_next;
    logic [NUM_W-1:0]  num_reg,     num_next;
    logic [32:0]       day_reg,     day_next;
    logic              ge_reg,      ge_next;

    // staged result
    logic [1:0]        res_mode_reg, res_mode_next;
    logic [15:0]       res_cnt_reg,  res_cnt_next;
    logic [31:0]       res_done_reg, res_done_next;
    logic [31:0]       res_step_reg, res_step_next;
    logic              res_pend_reg, res_pend_next;

    // output register
    logic              m_valid_reg;
    logic [1:0]        m_mode_reg;
    logic [15:0]       m_cnt_reg;
    logic [31:0]       m_done_reg;
    logic [31:0]       m_step_reg;
    logic              m_pend_reg;
    logic              load_out;

    // shared multiplier, operands chosen by the sequencer
    logic [MX_W-1:0]   mul_x;
    logic [MY_W-1:0]   mul_y;
    logic [NUM_W-1:0]  mul_p;

    div_req_t          div_req;
    div_stat_t         div_stat;

    logic [31:0]       idle_cl;
    logic [31:0]       planned32;
    logic [CMAX_W-1:0] counts;
    logic [31:0]       ticks;
    logic              s_take;

    tita_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .stat    (div_stat)
    );

    assign sps_eff  = (sps_reg == '0)  ? SPS_W'(1)  : sps_reg;
    assign tr_eff   = (tr_reg == '0)   ? TR_W'(1)   : tr_reg;
    assign wclk_eff = (wclk_reg == '0) ? WCLK_W'(1) : wclk_reg;
    assign cmax_eff = (cmax_reg == '0) ? CMAX_W'(1) :
                      (cmax_reg > WAKE_COUNT_LIMIT) ? WAKE_COUNT_LIMIT : cmax_reg;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_take    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign load_out  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign planned32 = 32'(planned_reg);

    // multiplier operand select
    always_comb begin
        mul_x = '0;
        mul_y = '0;
        case (state_reg)
            ST_PLAN_A: begin
                mul_x = MX_W'(cmax_eff);
                mul_y = MY_W'(tr_eff);
            end
            ST_PLAN_D: begin
                mul_x = MX_W'(idle_reg);
                mul_y = MY_W'(wclk_eff);
            end
            ST_FIN_A: begin
                mul_x = MX_W'(SECONDS_PER_DAY);
                mul_y = MY_W'(sps_eff);
            end
            ST_FIN_D: begin
                mul_x = num_reg[MX_W-1:0];
                mul_y = MY_W'(tr_eff);
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign mul_p = mul_x * mul_y;

    // divider request: dividend always comes from num_reg
    always_comb begin
        div_req.start   = 1'b0;
        div_req.hi      = num_reg[DIV_Q_W +: DIV_HI_W];
        div_req.lo      = num_reg[DIV_Q_W-1:0];
        div_req.divisor = wclk_eff;
        case (state_reg)
            ST_PLAN_B: begin
                div_req.start   = 1'b1;
                div_req.divisor = wclk_eff;
            end
            ST_PLAN_F: begin
                div_req.start   = 1'b1;
                div_req.divisor = DIV_D_W'(tr_eff);
            end
            ST_FIN_E: begin
                div_req.start   = 1'b1;
                div_req.divisor = DIV_D_W'(sps_eff);
            end
            default: begin
                div_req.start   = 1'b0;
            end
        endcase
    end

    // idle ticks limited by the wakeup range; a zero range keeps them as they are
    assign idle_cl = (div_stat.quo != '0 && idle_reg > div_stat.quo) ? div_stat.quo : idle_reg;

    // counts rounded up, kept in 1..max
    always_comb begin
        if (div_stat.ovf || div_stat.quo > 32'(cmax_eff)) begin
            counts = cmax_eff;
        end else if (div_stat.quo == '0) begin
            counts = CMAX_W'(1);
        end else begin
            counts = div_stat.quo[CMAX_W-1:0];
        end
    end

    // elapsed ticks limited to the plan, which already fits the tick width
    assign ticks = (div_stat.ovf || div_stat.quo > planned32) ? planned32 : div_stat.quo;

    // sequencer
    always_comb begin
        state_next    = state_reg;
        snap_next     = snap_reg;
        planned_next  = planned_reg;
        before_next   = before_reg;
        idle_next     = idle_reg;
        blk_next      = blk_reg;
        cap_next      = cap_reg;
        rv_next       = rv_reg;
        num_next      = num_reg;
        day_next      = day_reg;
        ge_next       = ge_reg;
        res_mode_next = res_mode_reg;
        res_cnt_next  = res_cnt_reg;
        res_done_next = res_done_reg;
        res_step_next = res_step_reg;
        res_pend_next = res_pend_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_take) begin
                    idle_next     = 32'(s_expected_idle_ticks[TW-1:0]);
                    blk_next      = s_stop_blocked;
                    cap_next      = s_rtc_subticks;
                    rv_next       = s_rtc_valid;
                    res_mode_next = MODE_NONE;
                    res_cnt_next  = '0;
                    res_done_next = '0;
                    res_step_next = '0;
                    res_pend_next = 1'b0;
                    state_next    = s_command ? ST_FIN_A : ST_PLAN_A;
                end
            end
            ST_PLAN_A: begin
                snap_next = 1'b0;
                if (idle_reg == '0) begin
                    planned_next = '0;
                    state_next   = ST_OUT;
                end else begin
                    num_next   = mul_p;
                    state_next = ST_PLAN_B;
                end
            end
            ST_PLAN_B: begin
                state_next = ST_PLAN_C;
            end
            ST_PLAN_C: begin
                if (div_stat.done) begin
                    idle_next    = idle_cl;
                    planned_next = idle_cl[TW-1:0];
                    state_next   = ST_PLAN_D;
                end
            end
            ST_PLAN_D: begin
                if (idle_reg < 32'(thr_reg) || blk_reg || deep_dis_reg) begin
                    res_mode_next = MODE_LIGHT;
                    state_next    = ST_OUT;
                end else if (!rv_reg) begin
                    res_mode_next = MODE_ABORT;
                    state_next    = ST_OUT;
                end else begin
                    num_next   = mul_p;
                    state_next = ST_PLAN_E;
                end
            end
            ST_PLAN_E: begin
                num_next   = num_reg + NUM_W'(tr_eff - TR_W'(1));
                state_next = ST_PLAN_F;
            end
            ST_PLAN_F: begin
                state_next = ST_PLAN_G;
            end
            ST_PLAN_G: begin
                if (div_stat.done) begin
                    res_mode_next = MODE_DEEP;
                    res_cnt_next  = 16'(counts - CMAX_W'(1));
                    before_next   = cap_reg;
                    snap_next     = 1'b1;
                    state_next    = ST_OUT;
                end
            end
            ST_FIN_A: begin
                snap_next = 1'b0;
                if (snap_reg && rv_reg) begin
                    day_next   = mul_p[32:0];
                    state_next = ST_FIN_B;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_FIN_B: begin
                ge_next    = cap_reg >= before_reg;
                // a capture beyond one day leaves nothing of the day
                num_next   = (33'(before_reg) > day_reg) ? '0
                                                         : NUM_W'(day_reg - 33'(before_reg));
                state_next = ST_FIN_C;
            end
            ST_FIN_C: begin
                num_next   = ge_reg ? NUM_W'(cap_reg - before_reg) : num_reg + NUM_W'(cap_reg);
                state_next = ST_FIN_D;
            end
            ST_FIN_D: begin
                num_next   = mul_p;
                state_next = ST_FIN_E;
            end
            ST_FIN_E: begin
                state_next = ST_FIN_F;
            end
            ST_FIN_F: begin
                if (div_stat.done) begin
                    res_done_next = ticks;
                    if (ticks != '0) begin
                        res_step_next = ticks - 32'd1;
                        res_pend_next = 1'b1;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            snap_reg    <= 1'b0;
            planned_reg <= '0;
            before_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            snap_reg    <= snap_next;
            planned_reg <= planned_next;
            before_reg  <= before_next;
        end
    end

    // working and staged result payload
    always_ff @(posedge aclk) begin
        idle_reg     <= idle_next;
        blk_reg      <= blk_next;
        cap_reg      <= cap_next;
        rv_reg       <= rv_next;
        num_reg      <= num_next;
        day_reg      <= day_next;
        ge_reg       <= ge_next;
        res_mode_reg <= res_mode_next;
        res_cnt_reg  <= res_cnt_next;
        res_done_reg <= res_done_next;
        res_step_reg <= res_step_next;
        res_pend_reg <= res_pend_next;
    end

    // configuration writes, indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sps_reg      <= SPS_RST;
            tr_reg       <= TR_RST;
            wclk_reg     <= WCLK_RST;
            cmax_reg     <= CMAX_RST;
            thr_reg      <= THR_RST;
            deep_dis_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SPS:       sps_reg      <= cfg_data[SPS_W-1:0];
                REG_TICK_RATE: tr_reg       <= cfg_data[TR_W-1:0];
                REG_WAKE_CLK:  wclk_reg     <= cfg_data[WCLK_W-1:0];
                REG_COUNT_MAX: cmax_reg     <= cfg_data[CMAX_W-1:0];
                REG_DEEP_THR:  thr_reg      <= cfg_data[THR_W-1:0];
                REG_DEEP_DIS:  deep_dis_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_mode_reg <= res_mode_reg;
            m_cnt_reg  <= res_cnt_reg;
            m_done_reg <= res_done_reg;
            m_step_reg <= res_step_reg;
            m_pend_reg <= res_pend_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_sleep_mode      = m_mode_reg;
    assign m_wakeup_counter  = m_cnt_reg;
    assign m_completed_ticks = m_done_reg;
    assign m_step_ticks      = m_step_reg;
    assign m_tick_pending    = m_pend_reg;

`ifndef SYNTHESIS
    // only an armed deep plan carries a wakeup load value
    a_wake_only_deep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sleep_mode != MODE_DEEP |-> m_wakeup_counter == '0)
        else $error("wakeup counter set on a result that is not deep armed");

    // pending tick exactly when ticks completed, step one less
    a_pend_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_tick_pending == (m_completed_ticks != '0)) &&
                    (!m_tick_pending || m_step_ticks == m_completed_ticks - 32'd1))
        else $error("tick pending or step ticks disagree with completed ticks");

    // divider is never restarted mid-division
    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_stat.busy)
        else $error("divider started while busy");

    // snapshot is only taken by an armed deep plan
    a_snap_from_deep: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(snap_reg) |-> $past(state_reg) == ST_PLAN_G && res_mode_reg == MODE_DEEP)
        else $error("snapshot set outside deep arming");
`endif

endmodule

>>> dv/tickless_idle_tick_accounting_unit_tb.sv
// tickless_idle_tick_accounting_unit_tb: self-checking testbench for the tickless idle tick unit
// depends on tita_pkg and tickless_idle_tick_accounting_unit; directed table, then random
// plan/finish sequences over several register settings, checked by an in-bench tick predictor
`timescale 1ns / 100ps

module tickless_idle_tick_accounting_unit_tb;
    import tita_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int DIRECTED_ROWS   = 24;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 110;
    // wait after the result queue empties, meant to cover one deep plan in flight
    localparam int DRAIN_CYCLES    = 80;
    localparam int SETTLE_CYCLES   = 100;
    // watchdog limit, well above the slowest correct run
    localparam int TIMEOUT_NS      = 8_000_000;

    localparam logic CMD_PLAN   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // ticks are kept to the tick width, never more than 32 bits
    localparam logic [63:0] TICK_MAX = (TICK_BITS_DEF >= 32) ? 64'hFFFF_FFFF :
                                       ((64'd1 << TICK_BITS_DEF) - 64'd1);

    typedef struct packed {
        logic        command;
        logic [31:0] idle_ticks;
        logic        stop_blocked;
        logic [31:0] rtc_subticks;
        logic        rtc_valid;
    } sleep_request_t;

    typedef struct packed {
        logic [1:0]  sleep_mode;
        logic [15:0] wakeup_counter;
        logic [31:0] completed_ticks;
        logic [31:0] step_ticks;
        logic        tick_pending;
    } sleep_outcome_t;

    // one line of the directed table; gold is used only where gold_known is set
    typedef struct packed {
        sleep_request_t req;
        logic           gold_known;
        sleep_outcome_t gold;
    } directed_row_t;

    typedef struct packed {
        logic [SPS_W-1:0]  sps;
        logic [TR_W-1:0]   tick_rate;
        logic [WCLK_W-1:0] wake_clk;
        logic [CMAX_W-1:0] count_max;
        logic [THR_W-1:0]  deep_thr;
        logic              deep_dis;
    } regset_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_command;
    logic [31:0]           s_expected_idle_ticks;
    logic                  s_stop_blocked;
    logic [31:0]           s_rtc_subticks;
    logic                  s_rtc_valid;
    logic                  m_valid;
    logic                  m_ready;
    logic [1:0]            m_sleep_mode;
    logic [15:0]           m_wakeup_counter;
    logic [31:0]           m_completed_ticks;
    logic [31:0]           m_step_ticks;
    logic                  m_tick_pending;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // register copies as the unit should hold them
    logic [SPS_W-1:0]  rate_sps;
    logic [TR_W-1:0]   rate_tick;
    logic [WCLK_W-1:0] rate_wake;
    logic [CMAX_W-1:0] wake_max;
    logic [THR_W-1:0]  deep_min_ticks;
    logic              deep_off;

    // sleep bookkeeping carried from a plan to its finish
    logic [31:0] sleep_start_sub;
    logic [31:0] sleep_plan_ticks;
    logic        sleep_armed;

    sleep_outcome_t awaited_outcomes[$];
    int             outcome_errors = 0;
    bit             tail_phase = 1'b0;

    tickless_idle_tick_accounting_unit #(
        .TICK_BITS(TICK_BITS_DEF)
    ) uut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_command            (s_command),
        .s_expected_idle_ticks(s_expected_idle_ticks),
        .s_stop_blocked       (s_stop_blocked),
        .s_rtc_subticks       (s_rtc_subticks),
        .s_rtc_valid          (s_rtc_valid),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_sleep_mode         (m_sleep_mode),
        .m_wakeup_counter     (m_wakeup_counter),
        .m_completed_ticks    (m_completed_ticks),
        .m_step_ticks         (m_step_ticks),
        .m_tick_pending       (m_tick_pending),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // a zero rate or count register reads as one
    function automatic logic [63:0] at_least_one(input logic [31:0] v);
        return (v == 32'd0) ? 64'd1 : {32'd0, v};
    endfunction

    // wakeup count limit, capped so the load value fits 16 bits
    function automatic logic [63:0] usable_count_max();
        logic [63:0] m;
        m = at_least_one(32'(wake_max));
        return (m > {47'd0, WAKE_COUNT_LIMIT}) ? {47'd0, WAKE_COUNT_LIMIT} : m;
    endfunction

    // tick accounting for one request; updates the sleep bookkeeping
    function automatic sleep_outcome_t account_sleep_request(input sleep_request_t r);
        sleep_outcome_t res;
        logic [63:0]    tr, idle, cmax, wclk, reach, counts;
        logic [63:0]    sps, day, start, elapsed, ticks;
        res = '0;
        tr  = at_least_one(32'(rate_tick));
        if (r.command == CMD_PLAN) begin
            idle = {32'd0, r.idle_ticks} & TICK_MAX;
            sleep_armed = 1'b0;
            if (idle != 64'd0) begin
                cmax  = usable_count_max();
                wclk  = at_least_one(32'(rate_wake));
                reach = cmax * tr / wclk;
                // a zero reach leaves the requested ticks alone
                if (reach != 64'd0 && idle > reach)
                    idle = reach;
                sleep_plan_ticks = idle[31:0];
                if (idle < deep_min_ticks || r.stop_blocked || deep_off) begin
                    res.sleep_mode = MODE_LIGHT;
                end else if (!r.rtc_valid) begin
                    res.sleep_mode = MODE_ABORT;
                end else begin
                    counts = (idle * wclk + tr - 64'd1) / tr;
                    if (counts == 64'd0)
                        counts = 64'd1;
                    else if (counts > cmax)
                        counts = cmax;
                    res.wakeup_counter = counts[15:0] - 16'd1;
                    res.sleep_mode     = MODE_DEEP;
                    sleep_start_sub    = r.rtc_subticks;
                    sleep_armed        = 1'b1;
                end
            end else begin
                sleep_plan_ticks = 32'd0;
            end
        end else begin
            if (sleep_armed && r.rtc_valid) begin
                sps   = at_least_one(32'(rate_sps));
                day   = SECONDS_PER_DAY * sps;
                start = {32'd0, sleep_start_sub};
                // wrap at midnight; a start past one day contributes nothing
                if ({32'd0, r.rtc_subticks} >= start)
                    elapsed = {32'd0, r.rtc_subticks} - start;
                else
                    elapsed = ((start > day) ? 64'd0 : day - start) + {32'd0, r.rtc_subticks};
                ticks = elapsed * tr / sps;
                if (ticks > TICK_MAX)
                    ticks = TICK_MAX;
                if (ticks > {32'd0, sleep_plan_ticks})
                    ticks = {32'd0, sleep_plan_ticks};
                res.completed_ticks = ticks[31:0];
                if (ticks != 64'd0) begin
                    res.step_ticks   = ticks[31:0] - 32'd1;
                    res.tick_pending = 1'b1;
                end
            end
            sleep_armed = 1'b0;
        end
        return res;
    endfunction

    // directed table, run with the reset register values
    function automatic directed_row_t directed_row(input int i);
        directed_row_t d;
        d = '0;
        case (i)
            // finish straight after reset, nothing armed
            0:  d = '{'{CMD_FINISH, 32'd0, 1'b0, 32'd123, 1'b1}, 1'b1,
                      '{MODE_NONE, 16'd0, 32'd0, 32'd0, 1'b0}};
            // zero idle ticks
            1:  d = '{'{CMD_PLAN, 32'd0, 1'b0, 32'd0, 1'b1}, 1'b1,
                      '{MODE_NONE, 16'd0, 32'd0, 32'd0, 1'b0}};
            2:  d = '{'{CMD_FINISH, 32'd0, 1'b0, 32'hFFFF_FFFF, 1'b1}, 1'b1,
                      '{MODE_NONE, 16'd0, 32'd0, 32'd0, 1'b0}};
            // below the deep threshold
            3:  d = '{'{CMD_PLAN, 32'd4, 1'b0, 32'd0, 1'b1}, 1'b1,
                      '{MODE_LIGHT, 16'd0, 32'd0, 32'd0, 1'b0}};
            // blocker present
            4:  d = '{'{CMD_PLAN, 32'd100, 1'b1, 32'd0, 1'b1}, 1'b1,
                      '{MODE_LIGHT, 16'd0, 32'd0, 32'd0, 1'b0}};
            // rtc capture failed, deep aborted
            5:  d = '{'{CMD_PLAN, 32'd100, 1'b0, 32'd0, 1'b0}, 1'b1,
                      '{MODE_ABORT, 16'd0, 32'd0, 32'd0, 1'b0}};
            // exactly at the threshold, then a five tick sleep
            6:  d = '{'{CMD_PLAN, 32'd5, 1'b0, 32'd1000, 1'b1}, 1'b0, '0};
            7:  d = '{'{CMD_FINISH, 32'd0, 1'b0, 32'd1164, 1'b1}, 1'b0, '0};
            // huge request clamps to the wakeup reach, full counter
            8:  d = '{'{CMD_PLAN, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b1}, 1'b1,
                      '{MODE_DEEP, 16'hFFFF, 32'd0, 32'd0, 1'b0}};
            // long elapsed time clamps to the planned ticks
            9:  d = '{'{CMD_FINISH, 32'd0, 1'b0, 32'hFFFF_FFFF, 1'b1}, 1'b1,
                      '{MODE_NONE, 16'd0, 32'd32000, 32'd31999, 1'b1}};
            // capture just before midnight, finish wraps
            10: d = '{'{CMD_PLAN, 32'd1000, 1'b0, 32'd2831155100, 1'b1}, 1'b0, '0};
            11: d = '{'{CMD_FINISH, 32'd0, 1'b0, 32'd50, 1'b1}, 1'b0, '0};
            // start capture beyond one day
            12: d = '{'{CMD_PLAN, 32'd1000, 1'b0, 32'hFFFF_FFFF, 1'b1}, 1'b0, '0};
            13: d = '{'{CMD_FINISH, 32'd0, 1'b0, 32'd7, 1'b1}, 1'b0, '0};
            // finish with a failed capture, then a second finish
            14: d = '{'{CMD_PLAN, 32'd20, 1'b0, 32'd500, 1'b1}, 1'b0, '0};
            15: d = '{'{CMD_FINISH, 32'd0, 1'b0, 32'd600, 1'b0}, 1'b1,
                      '{MODE_NONE, 16'd0, 32'd0, 32'd0, 1'b0}};
            16: d = '{'{CMD_FINISH, 32'd0, 1'b0, 32'd600, 1'b1}, 1'b1,
                      '{MODE_NONE, 16'd0, 32'd0, 32'd0, 1'b0}};
            // an intervening plan drops the armed capture
            17: d = '{'{CMD_PLAN, 32'd20, 1'b0, 32'd500, 1'b1}, 1'b0, '0};
            18: d = '{'{CMD_PLAN, 32'd0, 1'b0, 32'd0, 1'b1}, 1'b1,
                      '{MODE_NONE, 16'd0, 32'd0, 32'd0, 1'b0}};
            19: d = '{'{CMD_FINISH, 32'd0, 1'b0, 32'd100000, 1'b1}, 1'b1,
                      '{MODE_NONE, 16'd0, 32'd0, 32'd0, 1'b0}};
            // every flag against deep sleep at once
            20: d = '{'{CMD_PLAN, 32'd32001, 1'b1, 32'hFFFF_FFFF, 1'b0}, 1'b1,
                      '{MODE_LIGHT, 16'd0, 32'd0, 32'd0, 1'b0}};
            // finish with every field high, nothing armed
            21: d = '{'{CMD_FINISH, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1}, 1'b1,
                      '{MODE_NONE, 16'd0, 32'd0, 32'd0, 1'b0}};
            // top bit of the request, then zero elapsed
            22: d = '{'{CMD_PLAN, 32'h8000_0000, 1'b0, 32'h7FFF_FFFF, 1'b1}, 1'b1,
                      '{MODE_DEEP, 16'hFFFF, 32'd0, 32'd0, 1'b0}};
            default: d = '{'{CMD_FINISH, 32'd0, 1'b0, 32'h7FFF_FFFF, 1'b1}, 1'b1,
                      '{MODE_NONE, 16'd0, 32'd0, 32'd0, 1'b0}};
        endcase
        return d;
    endfunction

    // register settings per phase, extremes included; the last one runs without idling
    function automatic regset_t phase_setting(input int p);
        case (p)
            0: return '{16'd32768, 14'd1000,  21'd32768,   17'd65536,  8'd5,   1'b0};
            1: return '{16'd1,     14'd1,     21'd1,       17'd1,      8'd0,   1'b0};
            2: return '{16'd65535, 14'd16383, 21'd2097151, 17'd131071, 8'd255, 1'b0};
            // all zero, read as one
            3: return '{16'd0,     14'd0,     21'd0,       17'd0,      8'd0,   1'b0};
            4: return '{16'd32768, 14'd1000,  21'd2048,    17'd65536,  8'd5,   1'b1};
            5: return '{16'd1000,  14'd10000, 21'd1,       17'd100,    8'd20,  1'b0};
            // reach rounds to zero, request passes unclamped
            6: return '{16'd1,     14'd1,     21'd1048576, 17'd1,      8'd0,   1'b0};
            7: return '{16'd32768, 14'd100,   21'd1024,    17'd70000,  8'd1,   1'b0};
            8: return '{16'd50,    14'd9999,  21'd1000000, 17'd30000,  8'd3,   1'b0};
            default: return '{SPS_RST, TR_RST, WCLK_RST, CMAX_RST, THR_RST, 1'b0};
        endcase
    endfunction

    // plan request sized around the threshold and the wakeup reach
    function automatic sleep_request_t random_plan();
        sleep_request_t r;
        logic [63:0]    reach, day;
        reach = usable_count_max() * at_least_one(32'(rate_tick)) /
                at_least_one(32'(rate_wake));
        day   = SECONDS_PER_DAY * at_least_one(32'(rate_sps));
        r.command = CMD_PLAN;
        case ($urandom_range(0, 5))
            0:       r.idle_ticks = $urandom_range(0, deep_min_ticks + 2);
            1, 2:    r.idle_ticks = reach[31:0] + $urandom_range(0, 4) - 32'd2;
            3:       r.idle_ticks = $urandom;
            default: r.idle_ticks = $urandom_range(1, 3000);
        endcase
        r.stop_blocked = ($urandom_range(0, 9) == 0);
        r.rtc_valid    = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 4) == 0 || day > 64'hFFFF_FFFF)
            r.rtc_subticks = $urandom;
        else
            r.rtc_subticks = $urandom_range(0, day[31:0] - 32'd1);
        return r;
    endfunction

    // finish request whose capture lands near the planned sleep length
    function automatic sleep_request_t random_finish();
        sleep_request_t r;
        logic [63:0]    sps, tr, day, span, slack, cap;
        sps   = at_least_one(32'(rate_sps));
        tr    = at_least_one(32'(rate_tick));
        day   = SECONDS_PER_DAY * sps;
        span  = {32'd0, sleep_plan_ticks} * sps / tr;
        slack = sps / tr + 64'd2;
        if (slack > 64'd1000)
            slack = 64'd1000;
        case ($urandom_range(0, 4))
            0:       span = 64'd0;
            1:       span = span / 2;
            4:       span = span * 2;
            default: ;
        endcase
        span = span + $urandom_range(0, slack[31:0]);
        cap  = {32'd0, sleep_start_sub} + span;
        if (cap >= day)
            cap = cap - day;
        r.command      = CMD_FINISH;
        r.idle_ticks   = $urandom;
        r.stop_blocked = 1'($urandom_range(0, 1));
        r.rtc_subticks = (cap > 64'hFFFF_FFFF) ? $urandom : cap[31:0];
        r.rtc_valid    = ($urandom_range(0, 9) != 0);
        return r;
    endfunction

    function automatic sleep_request_t random_noise();
        sleep_request_t r;
        r.command      = 1'($urandom_range(0, 1));
        r.idle_ticks   = $urandom;
        r.stop_blocked = 1'($urandom_range(0, 1));
        r.rtc_subticks = $urandom;
        r.rtc_valid    = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            outcome_errors++;
        end
    endfunction

    // one request; valid stays high for a back-to-back request unless a sender gap drops it
    task automatic send_request(input sleep_request_t r, input logic gold_known,
                                input sleep_outcome_t gold);
        sleep_outcome_t predicted;
        s_valid               <= 1'b1;
        s_command             <= r.command;
        s_expected_idle_ticks <= r.idle_ticks;
        s_stop_blocked        <= r.stop_blocked;
        s_rtc_subticks        <= r.rtc_subticks;
        s_rtc_valid           <= r.rtc_valid;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = account_sleep_request(r);
        awaited_outcomes.push_back(gold_known ? gold : predicted);
        // random sender gap
        if (!tail_phase && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    // hold off until every outstanding result is back, then let the unit settle
    task automatic drain_results();
        s_valid <= 1'b0;
        while (awaited_outcomes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // leaves cfg_valid high; load_settings lowers it after the last write
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_SPS:       rate_sps       = value[SPS_W-1:0];
            REG_TICK_RATE: rate_tick      = value[TR_W-1:0];
            REG_WAKE_CLK:  rate_wake      = value[WCLK_W-1:0];
            REG_COUNT_MAX: wake_max       = value[CMAX_W-1:0];
            REG_DEEP_THR:  deep_min_ticks = value[THR_W-1:0];
            REG_DEEP_DIS:  deep_off       = value[0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input regset_t s);
        write_register(REG_SPS,       CFG_DATA_W'(s.sps));
        write_register(REG_TICK_RATE, CFG_DATA_W'(s.tick_rate));
        write_register(REG_WAKE_CLK,  CFG_DATA_W'(s.wake_clk));
        write_register(REG_COUNT_MAX, CFG_DATA_W'(s.count_max));
        write_register(REG_DEEP_THR,  CFG_DATA_W'(s.deep_thr));
        write_register(REG_DEEP_DIS,  CFG_DATA_W'(s.deep_dis));
        cfg_valid <= 1'b0;
    endtask

    // result side: random stall bursts, none in the last phase
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            if (!tail_phase) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
        end
    end

    // every accepted result against the oldest outstanding prediction
    always @(posedge aclk) begin : outcome_check
        sleep_outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_outcomes.size() == 0) begin
                $display("%0t ns: result with no request outstanding, mode %0d ticks %0d",
                         $time, m_sleep_mode, m_completed_ticks);
                outcome_errors++;
            end else begin
                want = awaited_outcomes.pop_front();
                check_field("sleep_mode",      32'(want.sleep_mode),     32'(m_sleep_mode));
                check_field("wakeup_counter",  32'(want.wakeup_counter),
                            32'(m_wakeup_counter));
                check_field("completed_ticks", want.completed_ticks, m_completed_ticks);
                check_field("step_ticks",      want.step_ticks,      m_step_ticks);
                check_field("tick_pending",    32'(want.tick_pending),   32'(m_tick_pending));
            end
        end
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        directed_row_t row;
        int            sent;
        bit            mid_drained;

        aresetn               = 1'b0;
        s_valid               = 1'b0;
        s_command             = CMD_PLAN;
        s_expected_idle_ticks = 32'd0;
        s_stop_blocked        = 1'b0;
        s_rtc_subticks        = 32'd0;
        s_rtc_valid           = 1'b0;
        cfg_valid             = 1'b0;
        cfg_index             = REG_SPS;
        cfg_data              = '0;

        // predictor starts from the reset register values
        rate_sps         = SPS_RST;
        rate_tick        = TR_RST;
        rate_wake        = WCLK_RST;
        wake_max         = CMAX_RST;
        deep_min_ticks   = THR_RST;
        deep_off         = 1'b0;
        sleep_start_sub  = 32'd0;
        sleep_plan_ticks = 32'd0;
        sleep_armed      = 1'b0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table with reset registers
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = directed_row(i);
            send_request(row.req, row.gold_known, row.gold);
        end

        // random plan/finish sequences, registers changed only while idle
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            tail_phase = (p == NUM_PHASES - 1);
            load_settings(phase_setting(p));
            sent        = 0;
            mid_drained = 1'b0;
            while (sent < ITEMS_PER_PHASE) begin
                // sender waits for the pipe to empty once per phase
                if (!mid_drained && sent >= ITEMS_PER_PHASE / 2) begin
                    drain_results();
                    mid_drained = 1'b1;
                end
                if ($urandom_range(0, 9) < 7) begin
                    send_request(random_plan(), 1'b0, '0);
                    sent++;
                    // mostly a matching finish, sometimes a broken sequence
                    if ($urandom_range(0, 19) < 17) begin
                        send_request(random_finish(), 1'b0, '0);
                        sent++;
                    end
                end else begin
                    send_request(random_noise(), 1'b0, '0);
                    sent++;
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (outcome_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
